FILE: rtl/core/positional_list_store_macros.svh
// Assertion macros for the positional list store.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pls_pkg.sv
// Package for the positional list store: command and result item types
// and the kind and status codes. No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_INS_AT    = 3'd2;
  localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
  localparam logic [2:0] KIND_DEL_BACK  = 3'd4;
  localparam logic [2:0] KIND_DEL_AT    = 3'd5;
  localparam logic [2:0] KIND_DUMP      = 3'd6;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BAD  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [31:0] value;
    logic        [6:0]  position;
  } cmd_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [6:0]  count;
    logic signed [31:0] entry_value;
    logic               last;
  } rsp_t;

endpackage

FILE: rtl/core/positional_list_store.sv
// Positional list store: bounded ordered list in a circular dual-port memory.
// Depends on pls_pkg and positional_list_store_macros.svh.
//
// Usage:
//   Present a command item on cmd and raise start; the item is taken at a
//   rising edge where start is high and busy is low. Each result item shows
//   on rsp for exactly one cycle with done high; the receiver cannot stall,
//   so it must take every item on the cycle it appears.
//   Timing by command kind:
//   - Front/back inserts and deletes, inserts at the back end, deletes of
//     the last entry, errors and full reports: result in the cycle after the
//     command; busy stays low, so a command may be taken every cycle.
//   - Insert or delete at a position that shifts n entries: the shift runs in
//     S_MOVE, then S_PUT writes an inserted value and gives the result; busy
//     stays high until the result shows. One read and one write port move
//     one entry per cycle (read, write next).
//   - Dump of n entries: n results on consecutive cycles, each entry read
//     and then registered; busy drops as the final result (last = 1) is shown.
//   Reset (rst, synchronous) empties the list and zeroes the head pointer.
//   Memory contents are not cleared; entries are only read after a write.
`timescale 1ns / 1ps

module positional_list_store #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pls_pkg::cmd_t cmd,
  output logic          done,
  output pls_pkg::rsp_t rsp
);
  import pls_pkg::*;

  `include "positional_list_store_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  typedef enum logic [1:0] {S_IDLE, S_MOVE, S_PUT, S_DUMP} state_t;
  typedef enum logic [1:0] {ACT_NONE, ACT_INS, ACT_DEL, ACT_DUMP} act_t;

  // Logical position to physical address, wrapping around the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                         input logic [CW-1:0] lg);
    logic [CW:0] sum;
    sum = (CW+1)'(hd) + (CW+1)'(lg);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // Entry memory, registered read.
  logic signed [31:0] mem [CAPACITY];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_wdata;
  logic signed [31:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Control and list state.
  state_t             state;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic               op_ins;
  logic [CW-1:0]      idx_reg;
  logic signed [31:0] val_reg;
  logic [CW-1:0]      cur;
  logic [CW-1:0]      moves_left;
  logic               pend;
  logic [CW-1:0]      pend_dst;
  logic               pend_last;

  logic acc;
  assign busy = (state != S_IDLE);
  assign acc  = start && !busy;

  // Decode of the incoming command against the current list.
  act_t          dec_act;
  logic [1:0]    dec_status;
  logic [CW-1:0] dec_idx;
  logic [CW-1:0] dec_moves;
  logic          need_move;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic          is_full;
  logic          is_empty;
  logic [AW-1:0] head_dec;

  assign pos_w    = PW'(cmd.position);
  assign cnt_w    = PW'(count);
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);

  always_comb begin
    dec_act    = ACT_NONE;
    dec_status = STATUS_OK;
    dec_idx    = '0;
    case (cmd.kind) inside
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
        if (is_full) begin
          dec_status = STATUS_FULL;
        end else if (cmd.kind == KIND_INS_FRONT) begin
          dec_act = ACT_INS;
        end else if (cmd.kind == KIND_INS_BACK) begin
          dec_act = ACT_INS;
          dec_idx = count;
        end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
          dec_status = STATUS_BAD;
        end else begin
          dec_act = ACT_INS;
          dec_idx = CW'(pos_w - PW'(1));
        end
      end
      KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
        if (is_empty) begin
          dec_status = STATUS_BAD;
        end else if (cmd.kind == KIND_DEL_FRONT) begin
          dec_act = ACT_DEL;
        end else if (cmd.kind == KIND_DEL_BACK) begin
          dec_act = ACT_DEL;
          dec_idx = count - CW'(1);
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          dec_status = STATUS_BAD;
        end else begin
          dec_act = ACT_DEL;
          dec_idx = CW'(pos_w - PW'(1));
        end
      end
      KIND_DUMP: begin
        if (is_empty) begin
          dec_status = STATUS_BAD;
        end else begin
          dec_act = ACT_DUMP;
        end
      end
      default: dec_status = STATUS_BAD;
    endcase
  end

  // Entries to shift: insert moves [idx, count-1] up by one, delete moves
  // [idx+1, count-1] down by one. Position zero goes through the head instead.
  assign dec_moves = (dec_act == ACT_INS) ? count - dec_idx
                                          : count - dec_idx - CW'(1);
  assign need_move = (dec_act == ACT_INS || dec_act == ACT_DEL) &&
                     (dec_idx != '0) && (dec_moves != '0);

  // Memory port steering.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = cmd.value;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        // Insert that needs no shift: write the value right away.
        if (acc && dec_act == ACT_INS && !need_move) begin
          mem_we    = 1'b1;
          mem_waddr = (dec_idx == '0) ? head_dec : phys(head, dec_idx);
        end
      end
      S_MOVE: begin
        // Read the source of the next move, write the one read last cycle.
        mem_raddr = phys(head, op_ins ? cur - CW'(1) : cur + CW'(1));
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head, pend_dst);
          mem_wdata = rd_data;
        end
      end
      S_PUT: begin
        if (op_ins) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head, idx_reg);
          mem_wdata = val_reg;
        end
      end
      S_DUMP: begin
        mem_raddr = phys(head, cur);
      end
      default: ;
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (dec_act)
              ACT_NONE: begin
                done            <= 1'b1;
                rsp.status      <= dec_status;
                rsp.count       <= 7'(count);
                rsp.entry_value <= '0;
                rsp.last        <= 1'b1;
              end
              ACT_INS: begin
                if (need_move) begin
                  op_ins     <= 1'b1;
                  idx_reg    <= dec_idx;
                  val_reg    <= cmd.value;
                  cur        <= count;
                  moves_left <= dec_moves;
                  pend       <= 1'b0;
                  state      <= S_MOVE;
                end else begin
                  if (dec_idx == '0) begin
                    head <= head_dec;
                  end
                  count           <= count + CW'(1);
                  done            <= 1'b1;
                  rsp.status      <= STATUS_OK;
                  rsp.count       <= 7'(count + CW'(1));
                  rsp.entry_value <= '0;
                  rsp.last        <= 1'b1;
                end
              end
              ACT_DEL: begin
                if (need_move) begin
                  op_ins     <= 1'b0;
                  idx_reg    <= dec_idx;
                  cur        <= dec_idx;
                  moves_left <= dec_moves;
                  pend       <= 1'b0;
                  state      <= S_MOVE;
                end else begin
                  if (dec_idx == '0) begin
                    head <= phys(head, CW'(1));
                  end
                  count           <= count - CW'(1);
                  done            <= 1'b1;
                  rsp.status      <= STATUS_OK;
                  rsp.count       <= 7'(count - CW'(1));
                  rsp.entry_value <= '0;
                  rsp.last        <= 1'b1;
                end
              end
              ACT_DUMP: begin
                cur   <= '0;
                pend  <= 1'b0;
                state <= S_DUMP;
              end
              default: ;
            endcase
          end
        end
        S_MOVE: begin
          if (moves_left != '0) begin
            pend_dst   <= cur;
            pend       <= 1'b1;
            cur        <= op_ins ? cur - CW'(1) : cur + CW'(1);
            moves_left <= moves_left - CW'(1);
          end else begin
            // Last pending write goes out this cycle.
            pend  <= 1'b0;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          count           <= op_ins ? count + CW'(1) : count - CW'(1);
          done            <= 1'b1;
          rsp.status      <= STATUS_OK;
          rsp.count       <= 7'(op_ins ? count + CW'(1) : count - CW'(1));
          rsp.entry_value <= '0;
          rsp.last        <= 1'b1;
          state           <= S_IDLE;
        end
        S_DUMP: begin
          if (cur != count) begin
            pend      <= 1'b1;
            pend_last <= (cur == count - CW'(1));
            cur       <= cur + CW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            done            <= 1'b1;
            rsp.status      <= STATUS_OK;
            rsp.count       <= 7'(count);
            rsp.entry_value <= rd_data;
            rsp.last        <= pend_last;
            if (pend_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PLS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `PLS_ASSERT_NOW(a_idle_no_write, state == S_IDLE && !start, !mem_we, "write while idle")
  `PLS_ASSERT_NOW(a_move_no_overlap, state == S_MOVE && pend && moves_left != '0, mem_waddr != mem_raddr, "shift read and write collide")
  `PLS_ASSERT_NOW(a_full_count, done && rsp.status == STATUS_FULL, rsp.count == 7'(CAPACITY), "full reported below capacity")
  `PLS_ASSERT_NEXT(a_dump_burst, done && !rsp.last, done, "gap inside a dump burst")

endmodule

FILE: sim/list_store_checker.sv
`timescale 1ns / 1ps
// Checker for the positional list store: keeps its own image of the list,
// turns each accepted command into the result items it must cause, and
// compares every result item against them. Depends on pls_pkg.

module list_store_checker #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  pls_pkg::cmd_t cmd,
  input  logic          done,
  input  pls_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);

  import pls_pkg::*;

  logic signed [31:0] list_image[$];
  rsp_t               awaited_results[$];
  int                 failures = 0;
  int                 reports  = 0;

  function automatic rsp_t result_item(logic [1:0] st, int count, logic signed [31:0] v,
                                       logic fin);
    rsp_t r;
    r.status      = st;
    r.count       = 7'(count);
    r.entry_value = v;
    r.last        = fin;
    return r;
  endfunction

  // Update the list image for one command and queue the results it causes.
  task automatic apply_command(cmd_t c);
    int         n;
    logic [1:0] st;
    n  = list_image.size();
    st = STATUS_OK;
    case (c.kind)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
        if (n >= CAPACITY) st = STATUS_FULL;
        else if (c.kind == KIND_INS_FRONT) list_image.push_front(c.value);
        else if (c.kind == KIND_INS_BACK) list_image.push_back(c.value);
        else if (c.position < 1 || c.position > n + 1) st = STATUS_BAD;
        else list_image.insert(int'(c.position) - 1, c.value);
      end
      KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
        if (n == 0) st = STATUS_BAD;
        else if (c.kind == KIND_DEL_FRONT) void'(list_image.pop_front());
        else if (c.kind == KIND_DEL_BACK) void'(list_image.pop_back());
        else if (c.position < 1 || c.position > n) st = STATUS_BAD;
        else list_image.delete(int'(c.position) - 1);
      end
      KIND_DUMP: begin
        if (n == 0) st = STATUS_BAD;
        else begin
          for (int i = 0; i < n; i++)
            awaited_results.push_back(result_item(STATUS_OK, n, list_image[i], i == n - 1));
          return;
        end
      end
      default: st = STATUS_BAD;
    endcase
    awaited_results.push_back(result_item(st, list_image.size(), 32'sd0, 1'b1));
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    if (awaited_results.size() == 0) begin
      failures++;
      if (reports < 10)
        $display("list_store_checker: unexpected result at %0t: %s=%0d %s=%0d %s=%0d %s=%0d",
                 $time, "status", got.status, "count", got.count,
                 "value", got.entry_value, "last", got.last);
      reports++;
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.entry_value !== want.entry_value || got.last !== want.last) begin
        failures++;
        if (reports < 10) begin
          $display("list_store_checker: mismatch at %0t", $time);
          $display("  expected status=%0d count=%0d value=%0d last=%0d",
                   want.status, want.count, want.entry_value, want.last);
          $display("  got      status=%0d count=%0d value=%0d last=%0d",
                   got.status, got.count, got.entry_value, got.last);
        end
        reports++;
      end
    end
  endtask

  // Results come from earlier commands, so check before predicting.
  always @(posedge clk) begin
    if (rst) begin
      list_image.delete();
      awaited_results.delete();
    end else begin
      if (done) check_result(rsp);
      if (start && !busy) apply_command(cmd);
    end
    pending    <= awaited_results.size();
    fail_count <= failures;
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the positional list store bench: clock, reset, command stimulus and
// the verdict. Depends on pls_pkg, positional_list_store and list_store_checker.

module testbench;

  import pls_pkg::*;

  localparam int         CAPACITY     = 64;
  localparam logic [2:0] KIND_UNUSED  = 3'd7;
  localparam int         IDLE_PERCENT = 13;
  // Longest legal quiet stretch is a full-depth shift plus a sender gap;
  // allow many times that.
  localparam int         STALL_LIMIT  = 1000;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         RANDOM_ITEMS = 178;

  typedef enum logic { FILLING, DRAINING } fill_phase_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  int         fail_count;
  int         pending;
  int         quiet_cycles = 0;
  logic [6:0] seen_count   = '0;
  logic       idle_allowed = 1'b1;

  positional_list_store #(.CAPACITY(CAPACITY)) uut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  list_store_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Track the list size as the block reports it; steer the random mix with it.
  always @(posedge clk) begin
    if (rst) seen_count <= '0;
    else if (done) seen_count <= rsp.count;
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** positional_list_store: FAILED **");
        $finish;
      end
    end
  end

  // Hand one item to the block. Optionally idle first, then hold start
  // high until an edge with busy low takes the item. start is left high on
  // return so back-to-back items keep it up without a glitch.
  task automatic send_command(input logic [2:0] kind, input logic signed [31:0] value,
                              input logic [6:0] position);
    int   gap;
    cmd_t next_cmd;
    gap = 0;
    if (idle_allowed && $urandom_range(99) < IDLE_PERCENT) gap = 1;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    next_cmd.kind     = kind;
    next_cmd.value    = value;
    next_cmd.position = position;
    cmd   <= next_cmd;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    fill_phase_t        phase;
    int                 bound_hits;
    int                 roll;
    logic [2:0]         kind;
    logic [6:0]         position;
    logic signed [31:0] value;

    phase      = FILLING;
    bound_hits = 0;

    // Hold reset, then release it once for the whole run.
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: dump, delete and bad-position insert errors on an empty list first.
    send_command(KIND_DUMP, 32'sd0, 7'd0);            // dump of an empty list
    send_command(KIND_DEL_FRONT, 32'sd0, 7'd0);       // delete from empty
    send_command(KIND_DEL_BACK, 32'sd0, 7'd0);
    send_command(KIND_DEL_AT, 32'sd0, 7'd1);
    send_command(KIND_INS_AT, 32'sd5, 7'd0);          // position below 1
    send_command(KIND_INS_AT, 32'sd6, 7'd2);          // position past count+1
    // Build a short list with the value extremes; front insert wraps the head.
    send_command(KIND_INS_FRONT, 32'sh7fffffff, 7'd0);
    send_command(KIND_INS_BACK, 32'sh80000000, 7'd127);
    send_command(KIND_INS_AT, -32'sd1, 7'd1);
    send_command(KIND_INS_AT, 32'sd0, 7'd4);          // at count+1, the back end
    send_command(KIND_INS_AT, 32'sh55555555, 7'd2);   // middle, shifts entries
    send_command(KIND_INS_AT, 32'sd7, 7'd127);        // far out of range
    send_command(KIND_DUMP, 32'sd0, 7'd0);
    // Delete paths: bad positions, middle, the last entry, both ends.
    send_command(KIND_DEL_AT, 32'sd0, 7'd0);
    send_command(KIND_DEL_AT, 32'sd0, 7'd6);          // past count
    send_command(KIND_DEL_AT, 32'sd0, 7'd3);
    send_command(KIND_DEL_AT, 32'sd0, 7'd4);          // last entry
    send_command(KIND_DEL_FRONT, 32'sd0, 7'd0);
    send_command(KIND_DEL_BACK, 32'sd0, 7'd0);
    send_command(KIND_UNUSED, 32'sh12345678, 7'd64);  // unused kind
    send_command(KIND_INS_AT, 32'shaaaaaaaa, 7'd1);
    send_command(KIND_DUMP, 32'sd0, 7'd0);

    // Random: fill the store to capacity, hit it with inserts while full,
    // drain it to empty, hit it with deletes while empty, and repeat.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Hold a long stretch with the sender never idling.
      idle_allowed = !(n >= 80 && n < 150);
      roll = $urandom_range(99);
      if (phase == FILLING) begin
        if (seen_count >= CAPACITY) begin
          kind = 3'($urandom_range(KIND_INS_AT, KIND_INS_FRONT));
          bound_hits++;
          if (bound_hits >= 4) begin
            phase      = DRAINING;
            bound_hits = 0;
          end
        end else if (roll < 80) kind = 3'($urandom_range(KIND_INS_AT, KIND_INS_FRONT));
        else if (roll < 92) kind = 3'($urandom_range(KIND_DEL_AT, KIND_DEL_FRONT));
        else if (roll < 97) kind = KIND_DUMP;
        else kind = KIND_UNUSED;
      end else begin
        if (seen_count == 0) begin
          kind = 3'($urandom_range(KIND_DEL_AT, KIND_DEL_FRONT));
          bound_hits++;
          if (bound_hits >= 3) begin
            phase      = FILLING;
            bound_hits = 0;
          end
        end else if (roll < 75) kind = 3'($urandom_range(KIND_DEL_AT, KIND_DEL_FRONT));
        else if (roll < 90) kind = 3'($urandom_range(KIND_INS_AT, KIND_INS_FRONT));
        else if (roll < 96) kind = KIND_DUMP;
        else kind = KIND_UNUSED;
      end
      // Mostly legal positions for the current size; the rest anywhere.
      if ($urandom_range(99) < 85) begin
        if (kind == KIND_INS_AT) position = 7'($urandom_range(seen_count + 1, 1));
        else position = 7'($urandom_range((seen_count > 0) ? seen_count : 1, 1));
      end else begin
        position = 7'($urandom_range(127, 0));
      end
      value = $signed($urandom());
      send_command(kind, value, position);
    end

    // Drop start, let every awaited result arrive, then watch a while longer
    // for stray results.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** positional_list_store: PASSED **");
    end else begin
      $display("** positional_list_store: FAILED **");
    end
    $finish;
  end

endmodule
